### hw/rtl/tli_pkg.sv
// ----------------------------------------------------------------------------
// tli_pkg
// Types and constants shared by the table linear interpolator modules.
// ----------------------------------------------------------------------------
package tli_pkg;

  localparam int KEY_W      = 32;
  localparam int VAL_W      = 17;
  localparam int FUNC_W     = 2;
  localparam int STAT_W     = 2;
  localparam int PROD_W     = KEY_W + VAL_W;
  localparam int DIV_STEPS  = VAL_W;
  localparam int DIVCNT_W   = 5;

  localparam logic [VAL_W-1:0] VALUE_MAX = 17'd65536;

  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  point_key;
    logic [VAL_W-1:0]  point_value;
  } tli_in_t;

  typedef struct packed {
    logic [VAL_W-1:0]  result_value;
    logic [STAT_W-1:0] status;
  } tli_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_MUL,
    ST_DIV_LOAD,
    ST_DIV,
    ST_FIN,
    ST_RESP
  } tli_state_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic decide;
    logic mul;
    logic div_load;
    logic div_step;
    logic fin;
    logic out_load;
  } tli_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic need_interp;
    logic div_done;
    logic out_free;
  } tli_sts_t;

endpackage

### hw/rtl/tli_ctrl.sv
// ----------------------------------------------------------------------------
// tli_ctrl
// Sequencer for one transaction: scan, decide, multiply and divide if interpolating, respond.
// ----------------------------------------------------------------------------
module tli_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tli_pkg::tli_sts_t sts,
  output tli_pkg::tli_cmd_t cmd
);

  tli_pkg::tli_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tli_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tli_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = tli_pkg::ST_SCAN;
      end
      tli_pkg::ST_SCAN: begin
        if (sts.scan_done) state_nxt = tli_pkg::ST_DECIDE;
      end
      tli_pkg::ST_DECIDE: begin
        state_nxt = sts.need_interp ? tli_pkg::ST_MUL : tli_pkg::ST_RESP;
      end
      tli_pkg::ST_MUL:      state_nxt = tli_pkg::ST_DIV_LOAD;
      tli_pkg::ST_DIV_LOAD: state_nxt = tli_pkg::ST_DIV;
      tli_pkg::ST_DIV: begin
        if (sts.div_done) state_nxt = tli_pkg::ST_FIN;
      end
      tli_pkg::ST_FIN:      state_nxt = tli_pkg::ST_RESP;
      tli_pkg::ST_RESP: begin
        if (sts.out_free) state_nxt = tli_pkg::ST_IDLE;
      end
      default:              state_nxt = tli_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      tli_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      tli_pkg::ST_SCAN:     cmd.scan     = 1'b1;
      tli_pkg::ST_DECIDE:   cmd.decide   = 1'b1;
      tli_pkg::ST_MUL:      cmd.mul      = 1'b1;
      tli_pkg::ST_DIV_LOAD: cmd.div_load = 1'b1;
      tli_pkg::ST_DIV:      cmd.div_step = !sts.div_done;
      tli_pkg::ST_FIN:      cmd.fin      = 1'b1;
      tli_pkg::ST_RESP:     cmd.out_load = sts.out_free;
      default:              cmd          = '0;
    endcase
  end

endmodule

### hw/rtl/tli_dp.sv
// ----------------------------------------------------------------------------
// tli_dp
// Point store, neighbor scan, multiplier, serial divider and output register.
// ----------------------------------------------------------------------------
module tli_dp #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tli_pkg::tli_in_t  in_data,
  input  tli_pkg::tli_cmd_t cmd,
  output tli_pkg::tli_sts_t sts,
  output logic              out_valid,
  input  logic              out_stall,
  output tli_pkg::tli_out_t out_data
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int KW    = tli_pkg::KEY_W;
  localparam int VW    = tli_pkg::VAL_W;
  localparam int PW    = tli_pkg::PROD_W;

  logic [KW-1:0] key_mem [TABLE_DEPTH];
  logic [VW-1:0] val_mem [TABLE_DEPTH];

  logic [tli_pkg::FUNC_W-1:0] func_r;
  logic [KW-1:0]              qkey_r;
  logic [VW-1:0]              qval_r;
  logic [CNT_W-1:0]           count_r;

  logic [CNT_W-1:0] rd_idx_r;
  logic             rd_pend_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic [KW-1:0]    rd_key_r;
  logic [VW-1:0]    rd_val_r;

  logic             found_r;
  logic [IDX_W-1:0] found_idx_r;
  logic [VW-1:0]    found_val_r;
  logic             have_lo_r, have_hi_r;
  logic [KW-1:0]    lo_key_r, hi_key_r;
  logic [VW-1:0]    lo_val_r, hi_val_r;

  logic [PW-1:0]              prod_r;
  logic                       neg_r;
  logic [KW-1:0]              den_r;
  logic [KW-1:0]              rem_r;
  logic [VW-1:0]              numlo_r;
  logic [VW-1:0]              quo_r;
  logic [tli_pkg::DIVCNT_W-1:0] div_cnt_r;

  logic [VW-1:0]              res_val_r;
  logic [tli_pkg::STAT_W-1:0] res_stat_r;
  logic [VW-1:0]              res_val_nxt;
  logic [tli_pkg::STAT_W-1:0] res_stat_nxt;
  logic                       out_valid_r;
  tli_pkg::tli_out_t          out_r;

  logic [CNT_W-1:0] scan_lim;
  logic             rd_more;
  logic             full;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [VW-1:0]    sat_val;
  logic [VW-1:0]    diff_mag;
  logic [KW:0]      rem_sh;
  logic             q_bit;

  assign sat_val = (in_data.point_value > tli_pkg::VALUE_MAX) ?
                   tli_pkg::VALUE_MAX : in_data.point_value;

  assign scan_lim = (func_r == tli_pkg::FUNC_INSERT || func_r == tli_pkg::FUNC_QUERY) ?
                    count_r : '0;
  assign rd_more  = rd_idx_r < scan_lim;
  assign full     = count_r == CNT_W'(TABLE_DEPTH);

  assign mem_we    = cmd.decide && func_r == tli_pkg::FUNC_INSERT && (found_r || !full);
  assign mem_waddr = found_r ? found_idx_r : count_r[IDX_W-1:0];

  assign diff_mag = (hi_val_r < lo_val_r) ? (lo_val_r - hi_val_r) : (hi_val_r - lo_val_r);

  assign rem_sh = {rem_r, numlo_r[VW-1]};
  assign q_bit  = rem_sh >= {1'b0, den_r};

  assign sts.scan_done   = !rd_more && !rd_pend_r;
  assign sts.need_interp = func_r == tli_pkg::FUNC_QUERY && count_r != '0 && !found_r &&
                           have_lo_r && have_hi_r;
  assign sts.div_done    = div_cnt_r == '0;
  assign sts.out_free    = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[mem_waddr] <= qkey_r;
      val_mem[mem_waddr] <= qval_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_key_r  <= key_mem[rd_idx_r[IDX_W-1:0]];
    rd_val_r  <= val_mem[rd_idx_r[IDX_W-1:0]];
    cmp_idx_r <= rd_idx_r[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.decide) begin
      if (func_r == tli_pkg::FUNC_CLEAR) begin
        count_r <= '0;
      end else if (func_r == tli_pkg::FUNC_INSERT && !found_r && !full) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
      rd_idx_r  <= '0;
    end else if (cmd.accept) begin
      rd_pend_r <= 1'b0;
      rd_idx_r  <= '0;
    end else if (cmd.scan) begin
      rd_pend_r <= rd_more;
      if (rd_more) rd_idx_r <= rd_idx_r + 1'b1;
    end else begin
      rd_pend_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r    <= in_data.func;
      qkey_r    <= in_data.point_key;
      qval_r    <= sat_val;
      found_r   <= 1'b0;
      have_lo_r <= 1'b0;
      have_hi_r <= 1'b0;
    end else if (cmd.scan && rd_pend_r) begin
      if (rd_key_r == qkey_r) begin
        found_r     <= 1'b1;
        found_idx_r <= cmp_idx_r;
        found_val_r <= rd_val_r;
      end
      if (rd_key_r > qkey_r && (!have_hi_r || rd_key_r < hi_key_r)) begin
        have_hi_r <= 1'b1;
        hi_key_r  <= rd_key_r;
        hi_val_r  <= rd_val_r;
      end
      if (rd_key_r < qkey_r && (!have_lo_r || rd_key_r > lo_key_r)) begin
        have_lo_r <= 1'b1;
        lo_key_r  <= rd_key_r;
        lo_val_r  <= rd_val_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= {{VW{1'b0}}, qkey_r - lo_key_r} * {{KW{1'b0}}, diff_mag};
      neg_r  <= hi_val_r < lo_val_r;
      den_r  <= hi_key_r - lo_key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd.div_load) begin
      div_cnt_r <= tli_pkg::DIVCNT_W'(tli_pkg::DIV_STEPS);
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem_r   <= prod_r[PW-1:VW];
      numlo_r <= prod_r[VW-1:0];
      quo_r   <= '0;
    end else if (cmd.div_step) begin
      rem_r   <= q_bit ? KW'(rem_sh - {1'b0, den_r}) : rem_sh[KW-1:0];
      numlo_r <= {numlo_r[VW-2:0], 1'b0};
      quo_r   <= {quo_r[VW-2:0], q_bit};
    end
  end

  always_comb begin
    res_val_nxt  = res_val_r;
    res_stat_nxt = res_stat_r;
    if (cmd.decide) begin
      res_val_nxt  = '0;
      res_stat_nxt = tli_pkg::STAT_OK;
      if (func_r == tli_pkg::FUNC_INSERT) begin
        if (!found_r && full) res_stat_nxt = tli_pkg::STAT_FULL;
      end else if (func_r == tli_pkg::FUNC_QUERY) begin
        priority if (count_r == '0) begin
          res_stat_nxt = tli_pkg::STAT_EMPTY;
        end else if (found_r) begin
          res_val_nxt = found_val_r;
        end else if (!have_hi_r) begin
          res_val_nxt = lo_val_r;
        end else if (!have_lo_r) begin
          res_val_nxt = hi_val_r;
        end else begin
          res_val_nxt = '0;
        end
      end
    end else if (cmd.fin) begin
      res_val_nxt = neg_r ? (lo_val_r - quo_r) : (lo_val_r + quo_r);
    end
  end

  always_ff @(posedge clk) begin
    res_val_r  <= res_val_nxt;
    res_stat_r <= res_stat_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.result_value <= res_val_r;
      out_r.status       <= res_stat_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### hw/rtl/table_linear_interpolator_top.sv
// ----------------------------------------------------------------------------
// table_linear_interpolator_top
// Point table with piecewise linear interpolation on query.
// ----------------------------------------------------------------------------
// The in_ channel carries one transaction per item: clear, insert or query.
// The out_ channel returns exactly one result per item, in order.
// Both channels complete a transaction when valid is high and stall is low.
// One item is processed at a time; in_stall is low only while idle.
// Clear and unused codes skip the scan; an insert or query scans the stored
// points one per cycle through the memory read port; an interpolating query
// then adds a multiply and a 17-step restoring divide.
// The finished result sits in an output register, so a new item is taken
// while the previous result is still stalled; the next result then waits.
// Reset empties the table (point count zero) and drops any pending result;
// stored points are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module table_linear_interpolator_top #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tli_pkg::tli_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tli_pkg::tli_out_t out_data
);

  tli_pkg::tli_cmd_t cmd;
  tli_pkg::tli_sts_t sts;

  tli_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tli_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
